FILE: design/spi_clock_divider_search_top_macros.svh
// Assertion macros for the clock divider search block
`ifndef SPI_CLOCK_DIVIDER_SEARCH_TOP_MACROS_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPICD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SPICD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/spicd_pkg.sv
// Types and constants shared by the clock divider search block
package spicd_pkg;

   localparam int HZ_W       = 27;
   localparam int DUTY_W     = 9;
   localparam int CODE_W     = 6;
   localparam int PRE_CODE_W = 13;
   localparam int N_W        = 7;
   localparam int PRE_W      = 14;
   localparam int PROD_W     = PRE_W + N_W;
   localparam int DIV_W      = 28;
   localparam int CNT_W      = $clog2(DIV_W + 1);
   localparam int HPROD_W    = 16;

   localparam logic [HZ_W-1:0]    SRC_RESET = HZ_W'(80000000);
   localparam logic [N_W-1:0]     N_FIRST   = N_W'(2);
   localparam logic [HPROD_W-1:0] H_ROUND   = HPROD_W'(127);
   localparam int                 H_SHIFT   = 8;

   typedef struct packed {
      logic [HZ_W-1:0]   target_hz;
      logic [DUTY_W-1:0] duty;
   } req_type;

   typedef struct packed {
      logic                  bypass;
      logic [CODE_W-1:0]     divider_code;
      logic [PRE_CODE_W-1:0] prescale_code;
      logic [CODE_W-1:0]     high_code;
      logic [CODE_W-1:0]     low_code;
      logic [HZ_W-1:0]       effective_hz;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_Q1_GO,
      S_Q1_RUN,
      S_PRE_GO,
      S_PRE_RUN,
      S_MUL,
      S_F_GO,
      S_F_RUN,
      S_CMP,
      S_FINISH
   } state_type;

endpackage

FILE: design/spicd_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
module spicd_serial_div (
   input  logic                                clock,
   input  logic                                reset,
   input  spicd_pkg::div_req_type              div_req,
   output logic                                div_done,
   output logic [spicd_pkg::DIV_W-1:0]         div_quotient
);
   import spicd_pkg::*;

   logic [DIV_W:0]   rem_ff, rem_in, rem_shift;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             ge;

   always_comb begin
      rem_shift = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      ge        = rem_shift >= {1'b0, dsr_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.dividend;
         dsr_in = div_req.divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? (rem_shift - {1'b0, dsr_ff}) : rem_shift;
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

FILE: design/spi_clock_divider_search_top.sv
// Clock divider search: picks divider and prescaler nearest a requested frequency,
// or bypass when the target exceeds three quarters of the source. In bypass the word
// goes straight to the finish state; otherwise each divider candidate takes three
// 28-step bit-serial divisions (two for a zero target) through the one shared divider.
// Throughput: one word at a time; the next is taken once the result is registered.
// Reset: synchronous, active high; the source register returns to 80 MHz.
`include "spi_clock_divider_search_top_macros.svh"

module spi_clock_divider_search_top #(
   parameter int MAX_DIVIDER  = 64,
   parameter int MAX_PRESCALE = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  spicd_pkg::req_type          req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output spicd_pkg::rsp_type          rsp_data,
   input  logic                        csr_wr_en,
   input  logic [spicd_pkg::HZ_W-1:0]  csr_wr_data
);
   import spicd_pkg::*;

   localparam logic [N_W-1:0]   N_LAST  = N_W'(MAX_DIVIDER);
   localparam logic [PRE_W-1:0] PRE_MAX = PRE_W'(MAX_PRESCALE);

   state_type state_ff, state_in;

   logic [HZ_W-1:0]   src_ff;
   logic [HZ_W-1:0]   hz_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic              byp_ff;
   logic [N_W-1:0]    n_ff;
   logic [HZ_W-1:0]   q1_ff;
   logic [PRE_W-1:0]  pre_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [HZ_W-1:0]   f_ff;
   logic [N_W-1:0]    best_n_ff;
   logic [PRE_W-1:0]  best_pre_ff;
   logic [HZ_W-1:0]   best_err_ff;
   logic [HZ_W-1:0]   best_f_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   div_req_type       div_req;
   logic              div_done;
   logic [DIV_W-1:0]  div_quotient;

   logic              req_accept;
   logic              out_free;
   logic              rsp_load;
   logic [HZ_W-1:0]   src_quarter;
   logic [HZ_W-1:0]   byp_limit;
   logic              byp_hit;
   logic [PRE_W-1:0]  pre_clamped;
   logic [HZ_W-1:0]   err;
   logic [HPROD_W-1:0] h_sum;
   logic [HPROD_W-H_SHIFT-1:0] h_raw;
   logic [N_W-1:0]    h_cnt;

   spicd_serial_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign src_quarter = src_ff >> 2;
   assign byp_limit   = src_quarter + {src_quarter[HZ_W-2:0], 1'b0};
   assign byp_hit     = req_data.target_hz > byp_limit;

   always_comb begin
      if (div_quotient == '0) begin
         pre_clamped = PRE_W'(1);
      end else if (div_quotient > DIV_W'(MAX_PRESCALE)) begin
         pre_clamped = PRE_MAX;
      end else begin
         pre_clamped = div_quotient[PRE_W-1:0];
      end
      err = (f_ff >= hz_ff) ? (f_ff - hz_ff) : (hz_ff - f_ff);
   end

   always_comb begin
      h_sum = HPROD_W'(duty_ff) * HPROD_W'(best_n_ff) + H_ROUND;
      h_raw = h_sum[HPROD_W-1:H_SHIFT];
      if (h_raw == '0) begin
         h_cnt = N_W'(1);
      end else if (h_raw > (HPROD_W-H_SHIFT)'(best_n_ff)) begin
         h_cnt = best_n_ff;
      end else begin
         h_cnt = h_raw[N_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = byp_hit ? S_FINISH : S_Q1_GO;
            end
         end
         S_Q1_GO:   state_in = S_Q1_RUN;
         S_Q1_RUN: begin
            if (div_done) begin
               state_in = S_PRE_GO;
            end
         end
         S_PRE_GO:  state_in = (hz_ff == '0) ? S_MUL : S_PRE_RUN;
         S_PRE_RUN: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL:     state_in = S_F_GO;
         S_F_GO:    state_in = S_F_RUN;
         S_F_RUN: begin
            if (div_done) begin
               state_in = S_CMP;
            end
         end
         S_CMP:     state_in = (n_ff >= N_LAST) ? S_FINISH : S_Q1_GO;
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall        = 1'b1;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(src_ff);
      div_req.divisor  = DIV_W'(n_ff);
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_Q1_GO:  div_req.start = 1'b1;
         S_PRE_GO: begin
            div_req.start    = (hz_ff != '0);
            div_req.dividend = DIV_W'(q1_ff) + DIV_W'(hz_ff >> 1);
            div_req.divisor  = DIV_W'(hz_ff);
         end
         S_F_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(src_ff);
            div_req.divisor  = DIV_W'(prod_ff);
         end
         S_FINISH: rsp_load = out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         if (byp_ff) begin
            rsp_data_in = '{bypass: 1'b1, divider_code: '0, prescale_code: '0,
                            high_code: '0, low_code: '0, effective_hz: src_ff};
         end else begin
            rsp_data_in.bypass        = 1'b0;
            rsp_data_in.divider_code  = CODE_W'(best_n_ff - N_W'(1));
            rsp_data_in.prescale_code = PRE_CODE_W'(best_pre_ff - PRE_W'(1));
            rsp_data_in.high_code     = CODE_W'(h_cnt - N_W'(1));
            rsp_data_in.low_code      = CODE_W'(best_n_ff - N_W'(1));
            rsp_data_in.effective_hz  = best_f_ff;
         end
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_ff       <= SRC_RESET;
         rsp_valid_ff <= 1'b0;
         n_ff         <= N_FIRST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            src_ff <= csr_wr_data;
         end
         if (req_accept) begin
            n_ff <= N_FIRST;
         end else if (state_ff == S_CMP) begin
            n_ff <= n_ff + N_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         hz_ff   <= req_data.target_hz;
         duty_ff <= req_data.duty;
         byp_ff  <= byp_hit;
      end
      if (state_ff == S_Q1_RUN && div_done) begin
         q1_ff <= div_quotient[HZ_W-1:0];
      end
      if (state_ff == S_PRE_GO) begin
         pre_ff <= PRE_MAX;
      end else if (state_ff == S_PRE_RUN && div_done) begin
         pre_ff <= pre_clamped;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= PROD_W'(pre_ff) * PROD_W'(n_ff);
      end
      if (state_ff == S_F_RUN && div_done) begin
         f_ff <= div_quotient[HZ_W-1:0];
      end
      // keep the later divider on equal error
      if (state_ff == S_CMP && (n_ff == N_FIRST || err <= best_err_ff)) begin
         best_n_ff   <= n_ff;
         best_pre_ff <= pre_ff;
         best_err_ff <= err;
         best_f_ff   <= f_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPICD_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != S_IDLE,
                      "accepted word did not start work")
   `SPICD_ASSERT_NOW(a_done_in_run, clock, reset, div_done,
                     state_ff == S_Q1_RUN || state_ff == S_PRE_RUN || state_ff == S_F_RUN,
                     "divider finished outside a wait state")
   `SPICD_ASSERT_NOW(a_bypass_zero, clock, reset, rsp_valid_ff && rsp_data_ff.bypass,
                     rsp_data_ff.divider_code == '0 && rsp_data_ff.prescale_code == '0 &&
                     rsp_data_ff.high_code == '0 && rsp_data_ff.low_code == '0,
                     "bypass word carries nonzero codes")
   `SPICD_ASSERT_NOW(a_high_fits, clock, reset, rsp_valid_ff && !rsp_data_ff.bypass,
                     rsp_data_ff.high_code <= rsp_data_ff.divider_code &&
                     rsp_data_ff.low_code == rsp_data_ff.divider_code,
                     "high count exceeds period")

endmodule

FILE: tb/spi_clock_divider_search_top_test.sv
// Self-checking testbench for the SPI clock divider search block
`timescale 1ns / 100ps

module spi_clock_divider_search_top_test;
   import spicd_pkg::*;

   localparam int          DIVIDER_LIMIT   = 64;
   localparam int          PRESCALE_LIMIT  = 8192;
   localparam int          DUTY_ROUND      = 127;
   localparam int          DUTY_SCALE      = 256;
   localparam logic [31:0] HZ_MAX          = 32'h07FF_FFFF;
   localparam int          SETTLE_CYCLES   = 12;
   localparam int          PRESSURE_HOLD   = 14000;
   localparam int          WATCHDOG_CYCLES = 40000;

   class divider_scoreboard;
      logic [31:0] source_hz;
      rsp_type     expected_settings[$];
      int          failures;
      int          words_checked;
      int          bypass_seen;

      function new();
         source_hz = 32'(SRC_RESET);
         failures = 0;
         words_checked = 0;
         bypass_seen = 0;
      endfunction

      function void set_source(logic [HZ_W-1:0] value);
         source_hz = 32'(value);
      endfunction

      function int pending();
         return expected_settings.size();
      endfunction

      function logic [HZ_W-1:0] f_of(logic [31:0] src, logic [31:0] pre, logic [31:0] n);
         logic [31:0] q;
         q = src / (pre * n);
         return q[HZ_W-1:0];
      endfunction

      function rsp_type search_divider(req_type r);
         logic [31:0] src, hz, duty, n, pre, f, err, h;
         logic [31:0] best_n, best_pre, best_err;
         logic        found;
         rsp_type     p;
         src = source_hz;
         hz = 32'(r.target_hz);
         duty = 32'(r.duty);
         p = '0;
         if (hz > (src / 4) * 3) begin
            p.bypass = 1'b1;
            p.effective_hz = src[HZ_W-1:0];
            return p;
         end
         found = 1'b0;
         best_n = 0;
         best_pre = 0;
         best_err = 0;
         for (n = 2; n <= DIVIDER_LIMIT; n++) begin
            if (hz == 0) begin
               pre = PRESCALE_LIMIT;
            end else begin
               pre = (src / n + hz / 2) / hz;
               if (pre < 1) pre = 1;
               if (pre > PRESCALE_LIMIT) pre = PRESCALE_LIMIT;
            end
            f = src / (pre * n);
            err = (f >= hz) ? f - hz : hz - f;
            if (!found || err <= best_err) begin
               found = 1'b1;
               best_err = err;
               best_n = n;
               best_pre = pre;
            end
         end
         h = (duty * best_n + DUTY_ROUND) / DUTY_SCALE;
         if (h < 1) h = 1;
         if (h > best_n) h = best_n;
         p.divider_code = best_n[CODE_W-1:0] - 1'b1;
         p.prescale_code = best_pre[PRE_CODE_W-1:0] - 1'b1;
         p.high_code = h[CODE_W-1:0] - 1'b1;
         p.low_code = best_n[CODE_W-1:0] - 1'b1;
         p.effective_hz = f_of(src, best_pre, best_n);
         return p;
      endfunction

      function void note_request(req_type r);
         expected_settings.push_back(search_divider(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_settings.size() == 0) begin
            failures++;
            $display("%0t: unexpected result word %h", $time, got);
            return;
         end
         want = expected_settings.pop_front();
         words_checked++;
         if (want.bypass) bypass_seen++;
         compare_field("bypass", 32'(want.bypass), 32'(got.bypass));
         compare_field("divider_code", 32'(want.divider_code), 32'(got.divider_code));
         compare_field("prescale_code", 32'(want.prescale_code), 32'(got.prescale_code));
         compare_field("high_code", 32'(want.high_code), 32'(got.high_code));
         compare_field("low_code", 32'(want.low_code), 32'(got.low_code));
         compare_field("effective_hz", 32'(want.effective_hz), 32'(got.effective_hz));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [HZ_W-1:0]  csr_wr_data;

   divider_scoreboard search_board = new();
   logic no_idling;
   int   hold_cycles;
   int   source_settings;

   spi_clock_divider_search_top #(
      .MAX_DIVIDER(DIVIDER_LIMIT),
      .MAX_PRESCALE(PRESCALE_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) search_board.note_request(req_data);
         if (rsp_valid && !rsp_stall) search_board.check_response(rsp_data);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle = 0;
         else
            idle++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            if (rsp_valid) stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (rsp_valid) stall_left = no_idling ? 0 : $urandom_range(0, 6);
         end
      end
   end

   task automatic send_request(input logic [31:0] hz, input logic [31:0] duty);
      int gap;
      gap = no_idling ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.target_hz = hz[HZ_W-1:0];
      req_data.duty = duty[DUTY_W-1:0];
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (search_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_source(input logic [31:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value[HZ_W-1:0];
      @(posedge clock);
      search_board.set_source(value[HZ_W-1:0]);
      @(negedge clock);
      csr_wr_en = 1'b0;
      source_settings++;
   endtask

   function automatic logic [31:0] pick_target(logic [31:0] src);
      logic [31:0] edge_hz;
      int          mode;
      edge_hz = (src / 4) * 3;
      mode = $urandom_range(0, 9);
      if (mode < 4) return src / $urandom_range(1, 600000);
      if (mode < 6) return $urandom_range(1, (edge_hz == 0) ? 1 : edge_hz);
      if (mode < 7) return $urandom_range(0, 1000);
      if (mode < 8 && edge_hz < HZ_MAX) return $urandom_range(edge_hz + 1, HZ_MAX);
      return $urandom_range(0, HZ_MAX);
   endfunction

   function automatic logic [31:0] pick_duty();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256);
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_request(pick_target(search_board.source_hz), pick_duty());
   endtask

   initial begin
      logic [31:0] src;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      no_idling = 1'b0;
      hold_cycles = 0;
      source_settings = 1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      send_request(1, 0);
      send_request(0, 128);
      send_request(60000000, 256);
      send_request(60000001, 128);
      send_request(HZ_MAX, 511);
      send_request(40000000, 128);
      send_request(1000000, 511);
      send_request(1000000, 257);
      send_request(1000000, 1);
      send_request(9765, 64);
      send_request(152, 200);
      send_request(12345678, 100);
      send_request(3000, 255);
      wait_drained();

      // hold the result side long enough for the block to back up its input
      hold_cycles = PRESSURE_HOLD;
      for (int i = 0; i < 4; i++)
         send_request(search_board.source_hz / $urandom_range(100, 500000), pick_duty());
      wait_drained();

      write_source(HZ_MAX);
      src = (HZ_MAX / 4) * 3;
      send_request(src, 128);
      send_request(src + 1, 128);
      send_request(1, 256);
      send_request(HZ_MAX, 0);
      send_random(60);
      wait_drained();

      write_source(0);
      send_request(0, 128);
      send_request(1, 0);
      send_random(8);
      wait_drained();

      write_source(1);
      send_request(0, 511);
      send_request(1, 128);
      send_random(8);
      wait_drained();

      write_source($urandom_range(1, HZ_MAX));
      no_idling = 1'b1;
      send_random(20);
      no_idling = 1'b0;
      send_random(40);
      wait_drained();

      write_source(50000000);
      send_random(60);
      wait_drained();

      $display("Checked %0d result words, %0d of them in bypass, over %0d source clock settings.",
               search_board.words_checked, search_board.bypass_seen, source_settings);
      $display("Directed edge cases, a long result hold-off and random requests with idling.");
      if (search_board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
